// ===== rtl/core/ahfd_pkg.sv =====
`default_nettype none

package ahfd_pkg;

   typedef logic [7:0] char_type;
   typedef logic [3:0] nibble_type;
   typedef logic [1:0] count_type;

   typedef enum logic {
      KIND_DATA    = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_LENGTH = 2'd1,
      STATUS_BAD_HEX    = 2'd2,
      STATUS_LRC        = 2'd3
   } status_type;

   typedef struct packed {
      char_type character;
      logic     end_of_frame;
   } req_payload_type;

   typedef struct packed {
      kind_type   kind;
      char_type   data_byte;
      status_type status;
   } rsp_payload_type;

   typedef struct packed {
      logic       good;
      nibble_type value;
   } hex_digit_type;

   localparam char_type CHAR_ZERO    = 8'h30;  // '0'
   localparam char_type CHAR_NINE    = 8'h39;  // '9'
   localparam char_type CHAR_UPPER_A = 8'h41;  // 'A'
   localparam char_type CHAR_UPPER_F = 8'h46;  // 'F'
   localparam char_type CHAR_LOWER_A = 8'h61;  // 'a'
   localparam char_type CHAR_LOWER_F = 8'h66;  // 'f'
   localparam char_type HEX_LETTER_OFFSET = 8'd10;

   // head + at least one hex pair (two payload chars) is 3; the count stops at 3
   localparam count_type CHARS_MIN_FRAME = 2'd3;

   function automatic hex_digit_type hex_decode(input char_type c);
      hex_digit_type d;
      char_type      v;
      d.good = 1'b1;
      v      = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = c - CHAR_ZERO;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         v = c - CHAR_UPPER_A + HEX_LETTER_OFFSET;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         v = c - CHAR_LOWER_A + HEX_LETTER_OFFSET;
      end else begin
         d.good = 1'b0;
      end
      d.value = v[3:0];
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ahfd_chan_if.sv =====
`default_nettype none

interface ahfd_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ascii_hex_frame_decoder_lrc.sv =====
// An accepted character's data byte or verdict, if any, shows in the next cycle.
// Throughput: one character per cycle unless a result stalls; hex decode and the
// 8-bit LRC add sit between the request port and the result register.
// A stalled result holds its register; a new character is still taken when
// the result is being consumed in the same cycle.
// Reset (synchronous): no result pending, decoder waits for a head character.
`default_nettype none

module ascii_hex_frame_decoder_lrc (
   input  wire logic   clock,
   input  wire logic   reset,
   ahfd_chan_if.sink   req_chan,
   ahfd_chan_if.source rsp_chan
);

   logic                        in_frame_ff, in_frame_in;
   logic                        second_half_ff, second_half_in;
   ahfd_pkg::nibble_type        high_nibble_ff, high_nibble_in;
   logic                        high_nibble_bad_ff, high_nibble_bad_in;
   ahfd_pkg::char_type          byte_sum_ff, byte_sum_in;
   ahfd_pkg::count_type         chars_seen_ff, chars_seen_in;
   logic                        hex_error_ff, hex_error_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ahfd_pkg::rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   logic                        req_accept;
   ahfd_pkg::req_payload_type   req_item;
   ahfd_pkg::hex_digit_type     digit;
   ahfd_pkg::char_type          pair_byte;
   ahfd_pkg::status_type        verdict;

   assign req_item         = req_chan.payload;
   assign req_chan.ready   = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   assign digit     = ahfd_pkg::hex_decode(req_item.character);
   assign pair_byte = {high_nibble_ff, digit.value};

   always_comb begin
      if (chars_seen_ff < ahfd_pkg::CHARS_MIN_FRAME || !second_half_ff) begin
         verdict = ahfd_pkg::STATUS_BAD_LENGTH;
      end else if (hex_error_ff) begin
         verdict = ahfd_pkg::STATUS_BAD_HEX;
      end else if (byte_sum_ff != '0) begin
         verdict = ahfd_pkg::STATUS_LRC;
      end else begin
         verdict = ahfd_pkg::STATUS_OK;
      end
   end

   always_comb begin
      in_frame_in        = in_frame_ff;
      second_half_in     = second_half_ff;
      high_nibble_in     = high_nibble_ff;
      high_nibble_bad_in = high_nibble_bad_ff;
      byte_sum_in        = byte_sum_ff;
      chars_seen_in      = chars_seen_ff;
      hex_error_in       = hex_error_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_chan.ready;
      rsp_payload_in     = rsp_payload_ff;

      if (req_accept) begin
         if (!in_frame_ff || req_item.end_of_frame) begin
            // head character or final character: frame state starts over
            second_half_in     = 1'b0;
            high_nibble_in     = '0;
            high_nibble_bad_in = 1'b0;
            byte_sum_in        = '0;
            hex_error_in       = 1'b0;
            in_frame_in        = !in_frame_ff && !req_item.end_of_frame;
            chars_seen_in      = in_frame_in ? 2'd1 : 2'd0;
            if (req_item.end_of_frame) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.kind      = ahfd_pkg::KIND_VERDICT;
               rsp_payload_in.data_byte = '0;
               rsp_payload_in.status    = in_frame_ff ? verdict
                                                      : ahfd_pkg::STATUS_BAD_LENGTH;
            end
         end else begin
            if (chars_seen_ff < ahfd_pkg::CHARS_MIN_FRAME) begin
               chars_seen_in = chars_seen_ff + 2'd1;
            end
            if (!second_half_ff) begin
               high_nibble_in     = digit.value;
               high_nibble_bad_in = !digit.good;
               second_half_in     = 1'b1;
            end else begin
               second_half_in = 1'b0;
               if (hex_error_ff || high_nibble_bad_ff || !digit.good) begin
                  hex_error_in = 1'b1;
               end else begin
                  byte_sum_in              = byte_sum_ff + pair_byte;
                  rsp_valid_in             = 1'b1;
                  rsp_payload_in.kind      = ahfd_pkg::KIND_DATA;
                  rsp_payload_in.data_byte = pair_byte;
                  rsp_payload_in.status    = ahfd_pkg::STATUS_OK;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff        <= 1'b0;
         second_half_ff     <= 1'b0;
         high_nibble_ff     <= '0;
         high_nibble_bad_ff <= 1'b0;
         byte_sum_ff        <= '0;
         chars_seen_ff      <= '0;
         hex_error_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         in_frame_ff        <= in_frame_in;
         second_half_ff     <= second_half_in;
         high_nibble_ff     <= high_nibble_in;
         high_nibble_bad_ff <= high_nibble_bad_in;
         byte_sum_ff        <= byte_sum_in;
         chars_seen_ff      <= chars_seen_in;
         hex_error_ff       <= hex_error_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   // the character count is nonzero exactly while a frame is open
   assert property (@(posedge clock) disable iff (reset)
      in_frame_ff == (chars_seen_ff != '0))
      else $error("character count out of step with frame state");

   // an open pair only exists inside a frame
   assert property (@(posedge clock) disable iff (reset)
      second_half_ff |-> in_frame_ff)
      else $error("pair half set outside a frame");

   // a final character always yields a verdict and closes the frame
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_item.end_of_frame) |=>
         (rsp_valid_ff && rsp_payload_ff.kind == ahfd_pkg::KIND_VERDICT && !in_frame_ff))
      else $error("final character did not produce a verdict");

   // data bytes never carry a status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.kind == ahfd_pkg::KIND_DATA) |->
         rsp_payload_ff.status == ahfd_pkg::STATUS_OK)
      else $error("data item with nonzero status");

endmodule

`default_nettype wire
